// ===== rtl/wwlt_pkg.sv =====
package wwlt_pkg;

    localparam int LOCK_ROWS    = 1024;
    localparam int WAITER_SLOTS = 8;
    localparam int TXN_ID_BITS  = 16;

    localparam int TXN_W    = 16;
    localparam int ROW_W    = 10;
    localparam int STATUS_W = 3;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 3'd0,
        ST_WAITING = 3'd1,
        ST_WOUNDED = 3'd2,
        ST_FREED   = 3'd3,
        ST_HANDOFF = 3'd4,
        ST_REMOVED = 3'd5,
        ST_FULL    = 3'd6
    } t_status;

endpackage

// ===== rtl/wwlt_in_if.sv =====
interface wwlt_in_if;

    logic                           valid;
    logic                           ready;
    wwlt_pkg::t_op                  operation;
    logic [wwlt_pkg::TXN_W-1:0]     txn_id;
    logic [wwlt_pkg::ROW_W-1:0]     row;

    modport source (
        output valid,
        output operation,
        output txn_id,
        output row,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  txn_id,
        input  row,
        output ready
    );

endinterface

// ===== rtl/wwlt_out_if.sv =====
interface wwlt_out_if;

    logic                           valid;
    logic                           ready;
    wwlt_pkg::t_status              status;
    logic [wwlt_pkg::TXN_W-1:0]     other_txn;
    logic                           other_valid;

    modport source (
        output valid,
        output status,
        output other_txn,
        output other_valid,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  other_txn,
        input  other_valid,
        output ready
    );

endinterface

// ===== rtl/wound_wait_lock_table_core.sv =====
// Channel  Dir  Beat fields                         Handshake
// i_in     in   operation, txn_id, row              valid / ready
// o_out    out  status, other_txn, other_valid      valid / ready
//
// An item passes in turn through row-reduce steps (only when LOCK_ROWS is
// below 1024), a table read, a scan of the waiter slots through one
// comparator and a decide step; no new item is taken until it leaves decide.
// After reset a clearing pass writes every row of the table to zero;
// i_in.ready stays low meanwhile.
// A finished result holds in the output register until taken; the next item
// is accepted meanwhile and waits at its final step for the register.
module wound_wait_lock_table_core #(
    parameter int LOCK_ROWS    = wwlt_pkg::LOCK_ROWS,
    parameter int WAITER_SLOTS = wwlt_pkg::WAITER_SLOTS,
    parameter int TXN_ID_BITS  = wwlt_pkg::TXN_ID_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wwlt_in_if.sink       i_in,
    wwlt_out_if.source    o_out
);

    localparam int ID_W     = TXN_ID_BITS;
    localparam int ADDR_W   = (LOCK_ROWS > 1) ? $clog2(LOCK_ROWS) : 1;
    localparam int SLOT_W   = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int ROW_IN_W = wwlt_pkg::ROW_W;
    localparam int OUT_W    = wwlt_pkg::TXN_W;
    localparam int SUB_W    = 2 * ROW_IN_W;
    localparam int STEP_W   = $clog2(ROW_IN_W);
    localparam bit NEED_MOD = LOCK_ROWS < (2 ** ROW_IN_W);

    localparam logic [SUB_W-1:0]  SUB_INIT  = SUB_W'(LOCK_ROWS) << (ROW_IN_W - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROW_IN_W - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(LOCK_ROWS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WAITER_SLOTS - 1);

    typedef struct packed {
        logic                               own_v;
        logic [ID_W-1:0]                    own_id;
        logic [WAITER_SLOTS-1:0]            wv;
        logic [WAITER_SLOTS-1:0][ID_W-1:0]  wid;
    } t_row;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_READ,
        S_SCAN,
        S_DECIDE
    } t_state;

    t_state                 r_state;
    logic [ADDR_W-1:0]      r_clr;
    wwlt_pkg::t_op          r_op;
    logic [ID_W-1:0]        r_id;
    logic [ROW_IN_W-1:0]    r_row;
    logic [SUB_W-1:0]       r_sub;
    logic [STEP_W-1:0]      r_step;
    logic [SLOT_W-1:0]      r_idx;
    logic                   r_hit;
    logic [SLOT_W-1:0]      r_hit_idx;
    logic                   r_free;
    logic [SLOT_W-1:0]      r_free_idx;
    logic                   r_best;
    logic [SLOT_W-1:0]      r_best_idx;
    logic [ID_W-1:0]        r_best_id;
    logic                   r_out_valid;
    wwlt_pkg::t_status      r_status;
    logic [ID_W-1:0]        r_other;
    logic                   r_other_ok;

    t_row                   r_mem [LOCK_ROWS];
    t_row                   r_q;

    logic                   w_out_free;
    logic [ADDR_W-1:0]      w_addr;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    t_row                   w_wdata;
    logic                   w_sv;
    logic [ID_W-1:0]        w_sid;
    logic                   w_eq;
    logic                   w_lt;
    logic                   w_own_eq;
    logic                   w_own_lt;
    t_row                   n_word;
    wwlt_pkg::t_status      n_status;
    logic [ID_W-1:0]        n_other;
    logic                   n_other_ok;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_addr     = ADDR_W'(r_row);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.other_txn   = OUT_W'(r_other);
    assign o_out.other_valid = r_other_ok;

    // shared slot comparator
    assign w_sv  = r_q.wv[r_idx];
    assign w_sid = r_q.wid[r_idx];
    assign w_eq  = (w_sid == r_id);
    assign w_lt  = (w_sid < r_best_id);

    assign w_own_eq = (r_q.own_id == r_id);
    assign w_own_lt = (r_q.own_id < r_id);

    always_comb begin
        n_word     = r_q;
        n_status   = wwlt_pkg::ST_REMOVED;
        n_other    = '0;
        n_other_ok = 1'b0;
        if (r_op == wwlt_pkg::OP_ACQUIRE) begin
            priority if (!r_q.own_v || w_own_eq) begin
                n_word.own_v  = 1'b1;
                n_word.own_id = r_id;
                if (r_hit) begin
                    n_word.wv[r_hit_idx]  = 1'b0;
                    n_word.wid[r_hit_idx] = '0;
                end
                n_status = wwlt_pkg::ST_GRANTED;
            end else if (w_own_lt) begin
                priority if (r_hit) begin
                    n_status = wwlt_pkg::ST_WAITING;
                end else if (!r_free) begin
                    n_status = wwlt_pkg::ST_FULL;
                end else begin
                    n_word.wv[r_free_idx]  = 1'b1;
                    n_word.wid[r_free_idx] = r_id;
                    n_status = wwlt_pkg::ST_WAITING;
                end
            end else begin
                n_other       = r_q.own_id;
                n_other_ok    = 1'b1;
                n_word.own_id = r_id;
                if (r_hit) begin
                    n_word.wv[r_hit_idx]  = 1'b0;
                    n_word.wid[r_hit_idx] = '0;
                end
                n_status = wwlt_pkg::ST_WOUNDED;
            end
        end else begin
            priority if (r_q.own_v && w_own_eq) begin
                if (r_best) begin
                    n_word.wv[r_best_idx]  = 1'b0;
                    n_word.wid[r_best_idx] = '0;
                    n_word.own_id = r_best_id;
                    n_other       = r_best_id;
                    n_other_ok    = 1'b1;
                    n_status      = wwlt_pkg::ST_HANDOFF;
                end else begin
                    n_word.own_v  = 1'b0;
                    n_word.own_id = '0;
                    n_status      = wwlt_pkg::ST_FREED;
                end
            end else begin
                if (r_hit) begin
                    n_word.wv[r_hit_idx]  = 1'b0;
                    n_word.wid[r_hit_idx] = '0;
                end
                n_status = wwlt_pkg::ST_REMOVED;
            end
        end
    end

    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_DECIDE) && w_out_free);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : w_addr;
    assign w_wdata = (r_state == S_CLEAR) ? t_row'('0) : n_word;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_state == S_READ) begin
            r_q <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_best      <= 1'b0;
            r_idx       <= '0;
            r_step      <= '0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.operation;
                        r_id    <= ID_W'(i_in.txn_id);
                        r_row   <= i_in.row;
                        r_sub   <= SUB_INIT;
                        r_step  <= STEP_LAST;
                        r_state <= NEED_MOD ? S_REDUCE : S_READ;
                    end
                end
                S_REDUCE: begin
                    if (SUB_W'(r_row) >= r_sub) begin
                        r_row <= r_row - r_sub[ROW_IN_W-1:0];
                    end
                    r_sub  <= r_sub >> 1;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_idx   <= '0;
                    r_hit   <= 1'b0;
                    r_free  <= 1'b0;
                    r_best  <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_sv) begin
                        if (w_eq && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_idx;
                        end
                        if (!r_best || w_lt) begin
                            r_best     <= 1'b1;
                            r_best_idx <= r_idx;
                            r_best_id  <= w_sid;
                        end
                    end else if (!r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == SLOT_LAST) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_status    <= n_status;
                        r_other     <= n_other;
                        r_other_ok  <= n_other_ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_clr   <= '0;
                end
            endcase
        end
    end

    a_decide_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && w_out_free) |=> r_out_valid)
        else $error("result not registered after final step");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("input ready during clearing pass");

    a_other_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_other_ok == (r_status == wwlt_pkg::ST_WOUNDED ||
                                        r_status == wwlt_pkg::ST_HANDOFF)))
        else $error("other_valid disagrees with status");

    a_hit_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hit && (r_state == S_SCAN || r_state == S_DECIDE)) |-> r_q.wv[r_hit_idx])
        else $error("matched waiter slot is empty");

endmodule
